[rtl/core/hpps_pkg.sv]
// Shared types and constants for the hot pixel projection statistics block.
// Used by every module under rtl/core; depends on nothing else.
`timescale 1ns / 1ps

package hpps_pkg;

    // Frame geometry defaults
    localparam int FRAME_WIDTH_DEF  = 80;
    localparam int FRAME_HEIGHT_DEF = 60;

    // Field and accumulator widths
    localparam int PIX_W   = 16;
    localparam int POS_W   = 8;
    localparam int DIR_W   = 16;
    localparam int CNT_W   = 17;
    localparam int PROJ_W  = 25;   // signed projection t
    localparam int MAG_W   = 24;   // |t|
    localparam int SQ_W    = 48;   // |t|^2
    localparam int SUM_W   = 40;
    localparam int SQSUM_W = 64;
    localparam int MEAN_W  = 16;
    localparam int VAR_W   = 22;

    // Serial divider sizes
    localparam int DVD_W   = 64;
    localparam int DSR_W   = 23;   // holds 64 * max count
    localparam int DCNT_W  = 6;

    localparam int M_W     = 31;   // clamped |sum| / n
    localparam int M2_W    = 62;

    localparam logic [CNT_W-1:0] COUNT_MAX = 17'h1FFFF;
    localparam logic [VAR_W-1:0] VAR_MAX   = 22'h3FFFFF;

    // APB register map
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam logic [1:0] REG_SUN_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_HORIZON_ROW   = 2'd1;
    localparam logic [1:0] REG_DIR_X         = 2'd2;
    localparam logic [1:0] REG_DIR_Y         = 2'd3;

    localparam logic [DIR_W-1:0] DIR_X_RESET = 16'd16384;
    localparam logic [DIR_W-1:0] DIR_Y_RESET = 16'd0;

    typedef struct packed {
        logic [PIX_W-1:0] sun_threshold;
        logic [POS_W-1:0] horizon_row;
        logic [DIR_W-1:0] dir_x;
        logic [DIR_W-1:0] dir_y;
    } cfg_t;

    // Which division the shared divider runs
    typedef enum logic [1:0] {
        DSEL_MEAN,
        DSEL_M,
        DSEL_E2
    } div_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PROJ,
        ST_SQUARE,
        ST_ACCUM,
        ST_PREP,
        ST_MEAN_GO,
        ST_MEAN_WAIT,
        ST_M_GO,
        ST_M_WAIT,
        ST_E2_GO,
        ST_E2_WAIT,
        ST_MULT,
        ST_DIFF,
        ST_ROUND,
        ST_PUBLISH
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic     accept;
        logic     proj;
        logic     square;
        logic     accum;
        logic     prep;
        logic     div_start;
        div_sel_t div_sel;
        logic     cap_mean;
        logic     cap_m;
        logic     cap_e2;
        logic     mult_m2;
        logic     diff;
        logic     round;
        logic     publish;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic last;
        logic empty;
        logic div_done;
    } dp_status_t;

endpackage

[rtl/core/hpps_regs.sv]
// APB configuration registers: threshold, horizon row and direction.
// Depends on hpps_pkg.
`timescale 1ns / 1ps

module hpps_regs
    import hpps_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sun_threshold <= '0;
            cfg_reg.horizon_row   <= '0;
            cfg_reg.dir_x         <= DIR_X_RESET;
            cfg_reg.dir_y         <= DIR_Y_RESET;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_SUN_THRESHOLD: cfg_reg.sun_threshold <= pwdata[PIX_W-1:0];
                REG_HORIZON_ROW:   cfg_reg.horizon_row   <= pwdata[POS_W-1:0];
                REG_DIR_X:         cfg_reg.dir_x         <= pwdata[DIR_W-1:0];
                REG_DIR_Y:         cfg_reg.dir_y         <= pwdata[DIR_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux, zero extended
    always_comb begin
        unique case (paddr[3:2])
            REG_SUN_THRESHOLD: prdata = {16'd0, cfg_reg.sun_threshold};
            REG_HORIZON_ROW:   prdata = {24'd0, cfg_reg.horizon_row};
            REG_DIR_X:         prdata = {16'd0, cfg_reg.dir_x};
            REG_DIR_Y:         prdata = {16'd0, cfg_reg.dir_y};
            default:           prdata = '0;
        endcase
    end

endmodule

[rtl/core/hpps_div.sv]
// Restoring serial divider, one quotient bit per cycle.
// Depends on hpps_pkg.
`timescale 1ns / 1ps

module hpps_div
    import hpps_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DSR_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    logic              busy_reg;
    logic              done_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0]  dvd_reg;   // dividend shifts out, quotient shifts in
    logic [DSR_W-1:0]  dsr_reg;
    logic [DSR_W-1:0]  rem_reg;

    logic [DSR_W:0]    rem_sh;
    logic [DSR_W:0]    rem_sub;
    logic              ge;

    // One restoring step
    assign rem_sh  = {rem_reg, dvd_reg[DVD_W-1]};
    assign rem_sub = rem_sh - {1'b0, dsr_reg};
    assign ge      = rem_sh >= {1'b0, dsr_reg};

    assign done     = done_reg;
    assign quotient = dvd_reg;

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == {DCNT_W{1'b1}}) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Data
    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], ge};
            rem_reg <= ge ? rem_sub[DSR_W-1:0] : rem_sh[DSR_W-1:0];
        end
    end

endmodule

[rtl/core/hpps_dp.sv]
// Datapath: position counters, projection, accumulators, end-of-frame math
// and the result word register. Depends on hpps_pkg and hpps_div.
`timescale 1ns / 1ps

module hpps_dp
    import hpps_pkg::*;
#(
    parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    input  dp_cmd_t           cmd,
    output dp_status_t        status,
    input  logic [PIX_W-1:0]  s_pixel,
    input  logic              s_frame_end,
    output logic [MEAN_W-1:0] m_mean,
    output logic [VAR_W-1:0]  m_variance,
    output logic [CNT_W-1:0]  m_hot_pixels,
    output logic              m_empty_res
);

    localparam logic [POS_W-1:0] COL_LAST = POS_W'(FRAME_WIDTH - 1);
    localparam logic [POS_W-1:0] ROW_LAST = POS_W'(FRAME_HEIGHT - 1);

    // Frame state
    logic [POS_W-1:0]   col_reg, row_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [SQSUM_W-1:0] sqsum_reg;
    logic               hot_reg, last_reg;

    // Per-pixel pipeline values
    logic [PROJ_W-1:0]  py_reg, px_reg, t_reg;
    logic [MAG_W-1:0]   mag_reg;
    logic [SQ_W-1:0]    sq_reg;

    // End-of-frame values
    logic [SUM_W-1:0]   smag_reg;
    logic [MEAN_W-1:0]  mean_reg;
    logic [M_W-1:0]     m_reg;
    logic [DVD_W-1:0]   e2_reg;
    logic [M2_W-1:0]    m2_reg;
    logic [SQSUM_W-1:0] diff_reg;
    logic [VAR_W-1:0]   var_reg;

    logic [POS_W:0]     row_off;
    logic [PROJ_W-1:0]  py_next, px_next, t_next, t_neg;
    logic [SUM_W-1:0]   sum_neg;
    logic [SUM_W:0]     mean_dvd;
    logic [DVD_W-1:0]   div_dvd;
    logic [DSR_W-1:0]   div_dsr;
    logic               div_done;
    logic [DVD_W-1:0]   div_q;
    logic [44:0]        var_round;
    logic [MEAN_W-1:0]  q_neg;

    // Projection products from the current position
    assign row_off = {1'b0, row_reg} - {1'b0, cfg.horizon_row};
    assign py_next = $signed({{(PROJ_W-POS_W-1){row_off[POS_W]}}, row_off})
                   * $signed({{(PROJ_W-DIR_W){cfg.dir_y[DIR_W-1]}}, cfg.dir_y});
    assign px_next = $signed({{(PROJ_W-POS_W){1'b0}}, col_reg})
                   * $signed({{(PROJ_W-DIR_W){cfg.dir_x[DIR_W-1]}}, cfg.dir_x});
    assign t_next  = py_reg + px_reg;
    assign t_neg   = ~t_next + 1'b1;

    assign sum_neg  = ~sum_reg + 1'b1;
    assign mean_dvd = {1'b0, smag_reg} + {{(SUM_W-CNT_W-4){1'b0}}, count_reg, 5'd0};
    assign q_neg    = ~div_q[MEAN_W-1:0] + 1'b1;

    // Rounding of the Q.28 variance to Q.8
    assign var_round = {1'b0, diff_reg[63:20]} + {44'd0, diff_reg[19]};

    // Divider operand select
    always_comb begin
        unique case (cmd.div_sel)
            DSEL_MEAN: begin
                div_dvd = {{(DVD_W-SUM_W-1){1'b0}}, mean_dvd};
                div_dsr = {count_reg, 6'd0};
            end
            DSEL_M: begin
                div_dvd = {{(DVD_W-SUM_W){1'b0}}, smag_reg};
                div_dsr = {6'd0, count_reg};
            end
            DSEL_E2: begin
                div_dvd = sqsum_reg;
                div_dsr = {6'd0, count_reg};
            end
            default: begin
                div_dvd = '0;
                div_dsr = '0;
            end
        endcase
    end

    hpps_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .done     (div_done),
        .quotient (div_q)
    );

    assign status.last     = last_reg;
    assign status.empty    = (count_reg == '0);
    assign status.div_done = div_done;

    // Counters and accumulators
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            row_reg   <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
            sqsum_reg <= '0;
            hot_reg   <= 1'b0;
            last_reg  <= 1'b0;
        end else if (cmd.publish) begin
            col_reg   <= '0;
            row_reg   <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
            sqsum_reg <= '0;
        end else begin
            if (cmd.accept) begin
                hot_reg  <= (s_pixel >= cfg.sun_threshold) && (count_reg != COUNT_MAX);
                last_reg <= s_frame_end;
                // raster position advance with wrap
                if (col_reg >= COL_LAST) begin
                    col_reg <= '0;
                    row_reg <= (row_reg >= ROW_LAST) ? '0 : row_reg + 1'b1;
                end else begin
                    col_reg <= col_reg + 1'b1;
                end
            end
            if (cmd.accum && hot_reg) begin
                count_reg <= count_reg + 1'b1;
                sum_reg   <= sum_reg + {{(SUM_W-PROJ_W){t_reg[PROJ_W-1]}}, t_reg};
                sqsum_reg <= sqsum_reg + {{(SQSUM_W-SQ_W){1'b0}}, sq_reg};
            end
        end
    end

    // Per-pixel and end-of-frame working registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            py_reg <= py_next;
            px_reg <= px_next;
        end
        if (cmd.proj) begin
            t_reg   <= t_next;
            mag_reg <= t_next[PROJ_W-1] ? t_neg[MAG_W-1:0] : t_next[MAG_W-1:0];
        end
        if (cmd.square) begin
            sq_reg <= mag_reg * mag_reg;
        end
        if (cmd.prep) begin
            smag_reg <= sum_reg[SUM_W-1] ? sum_neg : sum_reg;
        end
        // mean: round-half-away quotient, saturated to Q8.8
        if (cmd.cap_mean) begin
            if (sum_reg[SUM_W-1]) begin
                mean_reg <= (div_q > 64'd32768) ? 16'h8000 : q_neg;
            end else begin
                mean_reg <= (div_q > 64'd32767) ? 16'h7FFF : div_q[MEAN_W-1:0];
            end
        end
        if (cmd.cap_m) begin
            m_reg <= (div_q > 64'h7FFF_FFFF) ? {M_W{1'b1}} : div_q[M_W-1:0];
        end
        if (cmd.cap_e2) begin
            e2_reg <= div_q;
        end
        if (cmd.mult_m2) begin
            m2_reg <= m_reg * m_reg;
        end
        if (cmd.diff) begin
            diff_reg <= (e2_reg > {2'b00, m2_reg}) ? e2_reg - {2'b00, m2_reg} : '0;
        end
        if (cmd.round) begin
            var_reg <= (var_round > {23'd0, VAR_MAX}) ? VAR_MAX : var_round[VAR_W-1:0];
        end
    end

    // Result word register
    always_ff @(posedge aclk) begin
        if (cmd.publish) begin
            m_hot_pixels <= count_reg;
            m_empty_res  <= status.empty;
            m_mean       <= status.empty ? '0 : mean_reg;
            m_variance   <= status.empty ? '0 : var_reg;
        end
    end

endmodule

[rtl/core/hpps_ctrl.sv]
// Controller state machine: sequences pixel accumulation, the end-of-frame
// divisions and the result handshake. Depends on hpps_pkg.
`timescale 1ns / 1ps

module hpps_ctrl
    import hpps_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign m_valid = out_valid_reg;

    // State and result valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_ready;
        s_ready        = 1'b0;
        cmd            = '0;
        cmd.div_sel    = DSEL_MEAN;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_PROJ;
                end
            end
            ST_PROJ: begin
                cmd.proj   = 1'b1;
                state_next = ST_SQUARE;
            end
            ST_SQUARE: begin
                cmd.square = 1'b1;
                state_next = ST_ACCUM;
            end
            ST_ACCUM: begin
                cmd.accum  = 1'b1;
                state_next = status.last ? ST_PREP : ST_IDLE;
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = status.empty ? ST_PUBLISH : ST_MEAN_GO;
            end
            ST_MEAN_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DSEL_MEAN;
                state_next    = ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT: begin
                if (status.div_done) begin
                    cmd.cap_mean = 1'b1;
                    state_next   = ST_M_GO;
                end
            end
            ST_M_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DSEL_M;
                state_next    = ST_M_WAIT;
            end
            ST_M_WAIT: begin
                if (status.div_done) begin
                    cmd.cap_m  = 1'b1;
                    state_next = ST_E2_GO;
                end
            end
            ST_E2_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DSEL_E2;
                state_next    = ST_E2_WAIT;
            end
            ST_E2_WAIT: begin
                if (status.div_done) begin
                    cmd.cap_e2 = 1'b1;
                    state_next = ST_MULT;
                end
            end
            ST_MULT: begin
                cmd.mult_m2 = 1'b1;
                state_next  = ST_DIFF;
            end
            ST_DIFF: begin
                cmd.diff   = 1'b1;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.round  = 1'b1;
                state_next = ST_PUBLISH;
            end
            ST_PUBLISH: begin
                // load the result word once the output register is free
                if (!out_valid_reg || m_ready) begin
                    cmd.publish    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/hot_pixel_projection_stats_top.sv]
// Hot pixel projection statistics: top level joining registers, controller
// and datapath. Depends on hpps_pkg, hpps_regs, hpps_ctrl and hpps_dp.
// A pixel word passes through accept with projection products, sum, square and
// accumulate, and the next word is taken only after that. After the word that
// carries frame_end, a frame with hot pixels runs three divisions (mean,
// magnitude of the mean, mean square) on the shared bit-serial divider, each
// of them start, 64 steps and capture, before the result word is loaded. The
// result register lets the next frame's pixels be taken while a result waits.
`timescale 1ns / 1ps

module hot_pixel_projection_stats_top
    import hpps_pkg::*;
#(
    parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    // pixel input
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [PIX_W-1:0]  s_pixel,
    input  logic              s_frame_end,
    // frame result
    output logic              m_valid,
    input  logic              m_ready,
    output logic [MEAN_W-1:0] m_mean,
    output logic [VAR_W-1:0]  m_variance,
    output logic [CNT_W-1:0]  m_hot_pixels,
    output logic              m_empty_res
);

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    hpps_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hpps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    hpps_dp #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .cmd          (cmd),
        .status       (status),
        .s_pixel      (s_pixel),
        .s_frame_end  (s_frame_end),
        .m_mean       (m_mean),
        .m_variance   (m_variance),
        .m_hot_pixels (m_hot_pixels),
        .m_empty_res  (m_empty_res)
    );

endmodule

[bench/hpps_checker.sv]
// Checker for the hot pixel projection statistics block: follows register
// writes and both word channels, predicts every frame result and compares.
// Depends on hpps_pkg only.
`timescale 1ns / 1ps

module hpps_checker
    import hpps_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic              pready,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [PIX_W-1:0]  s_pixel,
    input  logic              s_frame_end,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [MEAN_W-1:0] m_mean,
    input  logic [VAR_W-1:0]  m_variance,
    input  logic [CNT_W-1:0]  m_hot_pixels,
    input  logic              m_empty_res,
    output int                stat_errors,
    output int                stats_pending,
    output int                frames_checked
);

    typedef struct packed {
        logic [MEAN_W-1:0] mean;
        logic [VAR_W-1:0]  variance;
        logic [CNT_W-1:0]  hot_pixels;
        logic              empty_res;
    } frame_stats_t;

    frame_stats_t stats_due[$];

    // register copies
    logic [PIX_W-1:0]        thr;
    logic [POS_W-1:0]        hrow;
    logic signed [DIR_W-1:0] dx;
    logic signed [DIR_W-1:0] dy;

    // raster position and running sums of the current frame
    logic [POS_W-1:0]   col;
    logic [POS_W-1:0]   row;
    logic [CNT_W-1:0]   hot;
    logic [SUM_W-1:0]   psum;
    logic [SQSUM_W-1:0] psq;

    task automatic clear_frame();
        col  = '0;
        row  = '0;
        hot  = '0;
        psum = '0;
        psq  = '0;
    endtask

    // Accumulate one pixel word; on frame end queue the frame's statistics.
    task automatic take_pixel(input logic [PIX_W-1:0] pix, input logic last);
        longint          t;
        longint unsigned mag, n, smag, den, q, m, m2, e2, diff, v;
        logic            neg;
        frame_stats_t    r;
        if (pix >= thr && hot != COUNT_MAX) begin
            t = (longint'(row) - longint'(hrow)) * longint'(dy) + longint'(col) * longint'(dx);
            mag = (t < 0) ? -t : t;
            hot++;
            psum += t[SUM_W-1:0];
            psq += mag * mag;
        end
        // raster walk, wraps on its own when frame end never comes
        if (col >= FRAME_WIDTH_DEF - 1) begin
            col = '0;
            row = (row >= FRAME_HEIGHT_DEF - 1) ? '0 : row + 1'b1;
        end else begin
            col++;
        end
        if (!last)
            return;
        if (hot == 0) begin
            r = '{mean: '0, variance: '0, hot_pixels: '0, empty_res: 1'b1};
        end else begin
            n    = hot;
            neg  = psum[SUM_W-1];
            smag = neg ? (64'd1 << SUM_W) - 64'(psum) : 64'(psum);
            // Q.14 sum to Q8.8 mean, nearest with ties away from zero
            den = n * 64;
            q   = (smag + den / 2) / den;
            if (neg)
                r.mean = (q > 32768) ? 16'h8000 : 16'(64'd0 - q);
            else
                r.mean = (q > 32767) ? 16'h7FFF : q[MEAN_W-1:0];
            // E[t^2] - m^2 in Q.28, rounded to the nearest Q.8
            m = smag / n;
            if (m > 64'h7FFF_FFFF)
                m = 64'h7FFF_FFFF;
            m2   = m * m;
            e2   = psq / n;
            diff = (e2 > m2) ? e2 - m2 : 64'd0;
            v    = (diff >> 20) + diff[19];
            if (v > VAR_MAX)
                v = VAR_MAX;
            r.variance   = v[VAR_W-1:0];
            r.hot_pixels = hot;
            r.empty_res  = 1'b0;
        end
        stats_due.push_back(r);
        clear_frame();
    endtask

    always @(posedge aclk) begin : watch
        frame_stats_t want;
        if (!aresetn) begin
            thr  = '0;
            hrow = '0;
            dx   = DIR_X_RESET;
            dy   = DIR_Y_RESET;
            clear_frame();
            stats_due.delete();
            stat_errors    = 0;
            frames_checked = 0;
        end else begin
            // register write
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_SUN_THRESHOLD: thr  = pwdata[PIX_W-1:0];
                    REG_HORIZON_ROW:   hrow = pwdata[POS_W-1:0];
                    REG_DIR_X:         dx   = pwdata[DIR_W-1:0];
                    REG_DIR_Y:         dy   = pwdata[DIR_W-1:0];
                    default: ;
                endcase
            end
            // result word against the oldest prediction
            if (m_valid && m_ready) begin
                if (stats_due.size() == 0) begin
                    stat_errors++;
                    if (stat_errors <= 10)
                        $display("%t: result word with no frame pending: mean %0d var %0d hot %0d",
                                 $realtime, $signed(m_mean), m_variance, m_hot_pixels);
                end else begin
                    want = stats_due.pop_front();
                    if (m_mean !== want.mean || m_variance !== want.variance ||
                        m_hot_pixels !== want.hot_pixels || m_empty_res !== want.empty_res) begin
                        stat_errors++;
                        if (stat_errors <= 10)
                            $display({"%t: frame %0d (exp/got) mean %0d/%0d var %0d/%0d ",
                                      "hot %0d/%0d empty %0b/%0b"},
                                     $realtime, frames_checked,
                                     $signed(want.mean), $signed(m_mean),
                                     want.variance, m_variance,
                                     want.hot_pixels, m_hot_pixels,
                                     want.empty_res, m_empty_res);
                    end
                    frames_checked++;
                end
            end
            // pixel word
            if (s_valid && s_ready)
                take_pixel(s_pixel, s_frame_end);
        end
        stats_pending = stats_due.size();
    end

endmodule

[bench/testbench.sv]
// Top of the hot pixel projection statistics bench: clock, reset, register
// writes and pixel stimulus; hpps_checker does prediction and comparison.
// Depends on hpps_pkg, hpps_checker and hot_pixel_projection_stats_top.
`timescale 1ns / 1ps

module testbench;
    import hpps_pkg::*;

    localparam int     LONG_PIXELS  = 200;      // two column wraps in one frame
    localparam int     PHASE_PIXELS = 150;
    localparam int     DRAIN_CYCLES = 250;
    localparam longint LIMIT_CYCLES = 1_000_000;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              s_valid;
    logic              s_ready;
    logic [PIX_W-1:0]  s_pixel;
    logic              s_frame_end;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [MEAN_W-1:0] m_mean;
    logic [VAR_W-1:0]  m_variance;
    logic [CNT_W-1:0]  m_hot_pixels;
    logic              m_empty_res;

    int stat_errors;
    int stats_pending;
    int frames_checked;

    int               send_idle_pct;
    int               recv_stall_pct;
    int               pixels_sent;
    logic [PIX_W-1:0] cur_thr;

    hot_pixel_projection_stats_top i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel      (s_pixel),
        .s_frame_end  (s_frame_end),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_mean       (m_mean),
        .m_variance   (m_variance),
        .m_hot_pixels (m_hot_pixels),
        .m_empty_res  (m_empty_res)
    );

    hpps_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pixel        (s_pixel),
        .s_frame_end    (s_frame_end),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_mean         (m_mean),
        .m_variance     (m_variance),
        .m_hot_pixels   (m_hot_pixels),
        .m_empty_res    (m_empty_res),
        .stat_errors    (stat_errors),
        .stats_pending  (stats_pending),
        .frames_checked (frames_checked)
    );

    always #10 aclk = ~aclk;

    // result side back-pressure
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // register write: setup cycle, then access cycle until pready
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, value};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input logic [15:0] thr, input logic [7:0] hrow,
                              input logic [15:0] dir_x, input logic [15:0] dir_y);
        write_reg(REG_SUN_THRESHOLD, thr);
        write_reg(REG_HORIZON_ROW, {8'd0, hrow});
        write_reg(REG_DIR_X, dir_x);
        write_reg(REG_DIR_Y, dir_y);
        cur_thr = thr;
    endtask

    // one pixel word, with random idle cycles ahead of it
    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_pixel     <= pix;
        s_frame_end <= last;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        pixels_sent++;
    endtask

    // mostly around the threshold so both sides of the compare get hit
    function automatic logic [PIX_W-1:0] pick_pixel();
        case ($urandom_range(3))
            0:       return cur_thr;
            1:       return (cur_thr == 0) ? 16'hFFFF : cur_thr - 16'd1;
            2:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_frame(input int len);
        for (int i = 0; i < len; i++)
            send_pixel(pick_pixel(), i == len - 1);
    endtask

    // idle the input, wait out every pending result and the divider tail
    task automatic drain();
        s_valid <= 1'b0;
        while (stats_pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    initial begin
        int len;
        int sent;
        aresetn        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        s_valid        = 1'b0;
        s_pixel        = '0;
        s_frame_end    = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        pixels_sent    = 0;
        cur_thr        = '0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: empty frame, threshold edges, both pixel extremes
        set_config(16'h8000, 8'd3, 16'd16384, 16'hC000);
        send_pixel(16'h0000, 1'b1);
        send_pixel(16'hFFFF, 1'b0);
        send_pixel(16'h8000, 1'b0);
        send_pixel(16'h7FFF, 1'b0);
        send_pixel(16'h0001, 1'b1);
        send_pixel(16'h8000, 1'b1);
        drain();
        // out-of-range directions, mean clipping at both ends
        set_config(16'hFFFF, 8'd255, 16'h7FFF, 16'h8000);
        send_pixel(16'hFFFF, 1'b0);
        send_pixel(16'hFFFE, 1'b0);
        send_pixel(16'hFFFF, 1'b1);
        drain();
        set_config(16'h0000, 8'd255, 16'h8000, 16'h7FFF);
        send_pixel(16'h1234, 1'b0);
        send_pixel(16'h0000, 1'b0);
        send_pixel(16'hFFFF, 1'b1);
        drain();

        // one frame longer than a row: the column wraps and the row advances
        set_config(16'h0000, 8'd255, 16'h0000, 16'h8000);
        for (int i = 0; i < LONG_PIXELS; i++)
            send_pixel(16'($urandom), i == LONG_PIXELS - 1);
        drain();

        // random frames under four idle mixes
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    set_config(16'h0000, 8'd0, 16'd16384, 16'hC000);
                end
                1: begin
                    send_idle_pct  = 68;
                    recv_stall_pct = 0;
                    set_config(16'hFFFF, 8'd255, 16'hC000, 16'd16384);
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 68;
                    set_config(16'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
                end
                default: begin
                    send_idle_pct  = 10;
                    recv_stall_pct = 10;
                    set_config(16'($urandom_range(16'h7000, 16'h9000)), 8'd30,
                               16'h8000, 16'h7FFF);
                end
            endcase
            sent = 0;
            while (sent < PHASE_PIXELS) begin
                len = ($urandom_range(7) == 0) ? $urandom_range(60, 170)
                                               : $urandom_range(1, 12);
                send_frame(len);
                sent += len;
            end
            drain();
        end

        $display("Sent %0d pixel words: directed frames, a %0d-pixel multi-row frame",
                 pixels_sent, LONG_PIXELS);
        $display("and four random phases with mixed idling; %0d frame results checked",
                 frames_checked);
        if (stat_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d frame results wrong or unexpected", stat_errors);
            $display("== FAIL ==");
        end
        $finish;
    end

    // run limit
    initial begin
        repeat (LIMIT_CYCLES) @(posedge aclk);
        $display("Run limit reached with %0d frame results outstanding", stats_pending);
        $display("== FAIL ==");
        $finish;
    end

endmodule

[sim.f]
rtl/core/hpps_pkg.sv
rtl/core/hpps_regs.sv
rtl/core/hpps_div.sv
rtl/core/hpps_dp.sv
rtl/core/hpps_ctrl.sv
rtl/core/hot_pixel_projection_stats_top.sv
bench/hpps_checker.sv
bench/testbench.sv
